// ===== rtl/last_note_priority_stack_macros.svh =====
// Assertion macros for the last-note-priority stack.
// Included by the top level; empty when SYNTHESIS is defined.
`ifndef LAST_NOTE_PRIORITY_STACK_MACROS_SVH
`define LAST_NOTE_PRIORITY_STACK_MACROS_SVH

`ifndef SYNTHESIS
`define LNPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lnps: assertion failed");
`define LNPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lnps: assertion failed");
`else
`define LNPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LNPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lnps_pkg.sv =====
// Shared constants, codes and types of the last-note-priority stack.
// No dependencies; used by every other file of the block but the assertion macros.
`default_nettype none

package lnps_pkg;

    localparam int CHANNELS_DEF = 2;
    localparam int NOTE_SLOTS   = 128;
    localparam int LINK_SPAN    = 256;

    localparam int KIND_W    = 2;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int SLOT_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [SLOT_W-1:0] SENTINEL = 8'd128;

    localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALL_OFF  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CH0_LOWEST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CH0_HIGHEST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CH1_LOWEST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CH1_HIGHEST = 2'd3;

    localparam logic [NOTE_W-1:0] RST_LOWEST  = 7'd0;
    localparam logic [NOTE_W-1:0] RST_HIGHEST = 7'd127;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_PUSH,
        S_SWEEP,
        S_FETCH,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic latch;
        logic decide;
        logic push;
        logic clear_wr;
        logic sweep_wr;
        logic cnt_clr;
        logic cnt_inc;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic sweep_done;
        logic all_off;
        logic need_push;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/lnps_if.sv =====
// Channel interfaces of the stack: event words in, result words out, register writes.
// Depends on lnps_pkg for field widths.
`default_nettype none

interface lnps_item_if;
    logic                             valid;
    logic                             ready;
    logic [lnps_pkg::KIND_W-1:0]      kind;
    logic                             chan;
    logic [lnps_pkg::NOTE_W-1:0]      note;
    logic [lnps_pkg::VEL_W-1:0]       velocity;

    modport source (output valid, kind, chan, note, velocity, input ready);
    modport sink   (input valid, kind, chan, note, velocity, output ready);
endinterface

interface lnps_result_if;
    logic                             valid;
    logic                             ready;
    logic [lnps_pkg::SLOT_W-1:0]      top_note;
    logic [lnps_pkg::SLOT_W-1:0]      top_velocity;
    logic                             any_held;

    modport source (output valid, top_note, top_velocity, any_held, input ready);
    modport sink   (input valid, top_note, top_velocity, any_held, output ready);
endinterface

interface lnps_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lnps_pkg::CFG_IDX_W-1:0]   index;
    logic [lnps_pkg::NOTE_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lnps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies beyond lnps_pkg for default sizes.
`default_nettype none

module lnps_ram #(
    parameter int  WIDTH = lnps_pkg::SLOT_W,
    parameter int  DEPTH = lnps_pkg::LINK_SPAN,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/lnps_ctrl.sv =====
// Sequencer of the stack: clearing pass, event decode, link update, held sweep, result.
// Depends on lnps_pkg for the state, command and status types.
`default_nettype none

module lnps_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire lnps_pkg::t_sts i_sts,
    output lnps_pkg::t_cmd      o_cmd
);

    lnps_pkg::t_state r_state;
    lnps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lnps_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lnps_pkg::S_CLEAR: begin
                if (i_sts.clear_done) n_state = lnps_pkg::S_IDLE;
            end
            lnps_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lnps_pkg::S_DECIDE;
            end
            lnps_pkg::S_DECIDE: begin
                if (i_sts.all_off) begin
                    n_state = lnps_pkg::S_SWEEP;
                end else if (i_sts.need_push) begin
                    n_state = lnps_pkg::S_PUSH;
                end else begin
                    n_state = lnps_pkg::S_FETCH;
                end
            end
            lnps_pkg::S_PUSH: begin
                n_state = lnps_pkg::S_FETCH;
            end
            lnps_pkg::S_SWEEP: begin
                if (i_sts.sweep_done) n_state = lnps_pkg::S_FETCH;
            end
            lnps_pkg::S_FETCH: begin
                n_state = lnps_pkg::S_RESULT;
            end
            lnps_pkg::S_RESULT: begin
                if (i_sts.out_free) n_state = lnps_pkg::S_IDLE;
            end
            default: begin
                n_state = lnps_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lnps_pkg::S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
            end
            lnps_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            lnps_pkg::S_DECIDE: begin
                o_cmd.decide  = 1'b1;
                o_cmd.cnt_clr = 1'b1;
            end
            lnps_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
            end
            lnps_pkg::S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
            end
            lnps_pkg::S_RESULT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lnps_dp.sv =====
// Datapath of the stack: link and held tables, top registers, range registers, result word.
// Depends on lnps_pkg and lnps_ram; driven by lnps_ctrl commands.
`default_nettype none

module lnps_dp #(
    parameter int CHANNELS = lnps_pkg::CHANNELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lnps_pkg::t_cmd                    i_cmd,
    output lnps_pkg::t_sts                         o_sts,
    input  wire logic [lnps_pkg::KIND_W-1:0]       i_kind,
    input  wire logic                              i_chan,
    input  wire logic [lnps_pkg::NOTE_W-1:0]       i_note,
    input  wire logic [lnps_pkg::VEL_W-1:0]        i_velocity,
    input  wire logic                              i_cfg_valid,
    input  wire logic [lnps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lnps_pkg::NOTE_W-1:0]       i_cfg_data,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic      [lnps_pkg::SLOT_W-1:0]       o_top_note,
    output logic      [lnps_pkg::SLOT_W-1:0]       o_top_velocity,
    output logic                                   o_any_held
);

    localparam int LINK_DEPTH = CHANNELS * lnps_pkg::LINK_SPAN;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int HELD_DEPTH = CHANNELS * lnps_pkg::NOTE_SLOTS;
    localparam int HELD_AW    = $clog2(HELD_DEPTH);
    localparam int HELD_DW    = lnps_pkg::VEL_W + 1;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW         = lnps_pkg::SLOT_W;
    localparam int NW         = lnps_pkg::NOTE_W;
    localparam int VW         = lnps_pkg::VEL_W;

    logic [lnps_pkg::KIND_W-1:0] r_kind;
    logic                        r_chan;
    logic [NW-1:0]               r_note;
    logic [VW-1:0]               r_vel;
    logic [SW-1:0]               r_top [CHANNELS];
    logic [NW-1:0]               r_lo0, r_hi0, r_lo1, r_hi1;
    logic [LINK_AW-1:0]          r_cnt;
    logic                        r_out_valid;
    logic [SW-1:0]               r_out_note;
    logic [SW-1:0]               r_out_vel;
    logic                        r_out_any;

    logic [CH_W-1:0]    ch_idx;
    logic               chan_ok;
    logic [SW-1:0]      top_cur;
    logic [SW-1:0]      note8;
    logic [NW-1:0]      lo, hi;
    logic               in_rng, is_top, mark;
    logic               do_on, do_off, do_all, do_unlink, need_push;
    logic [SW-1:0]      prev_rd, next_rd;
    logic [HELD_DW-1:0] held_rd;

    logic               next_we, prev_we, held_we;
    logic [LINK_AW-1:0] next_wa, prev_wa, link_ra;
    logic [SW-1:0]      next_wd, prev_wd;
    logic [HELD_AW-1:0] held_wa, held_ra;
    logic [HELD_DW-1:0] held_wd;
    logic               top_we;
    logic [SW-1:0]      n_top;

    // hold the event word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_chan <= i_chan;
            r_note <= i_note;
            r_vel  <= i_velocity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo0 <= lnps_pkg::RST_LOWEST;
            r_hi0 <= lnps_pkg::RST_HIGHEST;
            r_lo1 <= lnps_pkg::RST_LOWEST;
            r_hi1 <= lnps_pkg::RST_HIGHEST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lnps_pkg::REG_CH0_LOWEST:  r_lo0 <= i_cfg_data;
                lnps_pkg::REG_CH0_HIGHEST: r_hi0 <= i_cfg_data;
                lnps_pkg::REG_CH1_LOWEST:  r_lo1 <= i_cfg_data;
                lnps_pkg::REG_CH1_HIGHEST: r_hi1 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign ch_idx  = CH_W'(r_chan);
    assign chan_ok = (int'(r_chan) < CHANNELS);
    assign top_cur = chan_ok ? r_top[ch_idx] : lnps_pkg::SENTINEL;
    assign note8   = {1'b0, r_note};
    assign lo      = r_chan ? r_lo1 : r_lo0;
    assign hi      = r_chan ? r_hi1 : r_hi0;
    assign in_rng  = (r_note >= lo) && (r_note <= hi);
    assign is_top  = (note8 == top_cur);
    assign mark    = held_rd[VW];

    assign do_on     = chan_ok && (r_kind == lnps_pkg::KIND_NOTE_ON) && in_rng;
    assign do_off    = chan_ok && (r_kind == lnps_pkg::KIND_NOTE_OFF) && in_rng && mark;
    assign do_all    = chan_ok && (r_kind == lnps_pkg::KIND_ALL_OFF);
    assign do_unlink = ((do_on && mark) || do_off) && !is_top;
    assign need_push = do_on && !is_top;

    // read the slot of the arriving word, then the top's velocity
    assign link_ra = i_cmd.latch ? LINK_AW'({i_chan, 1'b0, i_note})
                                 : LINK_AW'({r_chan, note8});
    assign held_ra = i_cmd.latch ? HELD_AW'({i_chan, i_note})
                                 : HELD_AW'({r_chan, top_cur[NW-1:0]});

    always_comb begin
        next_we = 1'b0;
        next_wa = r_cnt;
        next_wd = lnps_pkg::SENTINEL;
        prev_we = 1'b0;
        prev_wa = r_cnt;
        prev_wd = lnps_pkg::SENTINEL;
        if (i_cmd.clear_wr) begin
            next_we = 1'b1;
            prev_we = 1'b1;
        end else if (i_cmd.decide && do_unlink) begin
            next_we = 1'b1;
            next_wa = LINK_AW'({r_chan, prev_rd});
            next_wd = next_rd;
            prev_we = 1'b1;
            prev_wa = LINK_AW'({r_chan, next_rd});
            prev_wd = prev_rd;
        end else if (i_cmd.push) begin
            next_we = 1'b1;
            next_wa = LINK_AW'({r_chan, top_cur});
            next_wd = note8;
            prev_we = 1'b1;
            prev_wa = LINK_AW'({r_chan, note8});
            prev_wd = top_cur;
        end
    end

    always_comb begin
        held_we = 1'b0;
        held_wa = r_cnt[HELD_AW-1:0];
        held_wd = '0;
        if (i_cmd.clear_wr) begin
            held_we = 1'b1;
        end else if (i_cmd.sweep_wr) begin
            held_we = 1'b1;
            held_wa = HELD_AW'({r_chan, r_cnt[NW-1:0]});
        end else if (i_cmd.decide && (do_on || do_off)) begin
            held_we = 1'b1;
            held_wa = HELD_AW'({r_chan, r_note});
            held_wd = do_on ? {1'b1, r_vel} : '0;
        end
    end

    always_comb begin
        top_we = 1'b0;
        n_top  = lnps_pkg::SENTINEL;
        if (i_cmd.decide && do_all) begin
            top_we = 1'b1;
        end else if (i_cmd.decide && do_off && is_top) begin
            top_we = 1'b1;
            n_top  = prev_rd;
        end else if (i_cmd.push) begin
            top_we = 1'b1;
            n_top  = note8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_top[i] <= lnps_pkg::SENTINEL;
            end
        end else if (top_we) begin
            r_top[ch_idx] <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (chan_ok && (top_cur != lnps_pkg::SENTINEL)) begin
                r_out_note <= top_cur;
                r_out_vel  <= {1'b0, held_rd[VW-1:0]};
                r_out_any  <= 1'b1;
            end else begin
                r_out_note <= lnps_pkg::SENTINEL;
                r_out_vel  <= lnps_pkg::SENTINEL;
                r_out_any  <= 1'b0;
            end
        end
    end

    lnps_ram #(.WIDTH(SW), .DEPTH(LINK_DEPTH)) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_we),
        .i_wr_addr (next_wa),
        .i_wr_data (next_wd),
        .i_rd_addr (link_ra),
        .o_rd_data (next_rd)
    );

    lnps_ram #(.WIDTH(SW), .DEPTH(LINK_DEPTH)) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_we),
        .i_wr_addr (prev_wa),
        .i_wr_data (prev_wd),
        .i_rd_addr (link_ra),
        .o_rd_data (prev_rd)
    );

    lnps_ram #(.WIDTH(HELD_DW), .DEPTH(HELD_DEPTH)) u_held_ram (
        .i_clk     (i_clk),
        .i_wr_en   (held_we),
        .i_wr_addr (held_wa),
        .i_wr_data (held_wd),
        .i_rd_addr (held_ra),
        .o_rd_data (held_rd)
    );

    assign o_sts.clear_done = (r_cnt == LINK_AW'(LINK_DEPTH - 1));
    assign o_sts.sweep_done = (r_cnt[NW-1:0] == {NW{1'b1}});
    assign o_sts.all_off    = do_all;
    assign o_sts.need_push  = need_push;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_top_note     = r_out_note;
    assign o_top_velocity = r_out_vel;
    assign o_any_held     = r_out_any;

endmodule

`default_nettype wire

// ===== rtl/last_note_priority_stack.sv =====
// Flow: an event word taken in idle is decoded; a note on that moves the top adds a push
// step (the link tables take one write each per cycle); all notes off adds a sweep of the
// channel's 128 held-table entries, one per cycle. The top's velocity is then fetched and
// the result word registered once the last one is taken; then the next event word is taken.
// Reset: synchronous, active low; then a clearing pass over all CHANNELS*256 link entries
// and the held table holds event input not ready. Register writes are taken at any time.
`default_nettype none
`include "last_note_priority_stack_macros.svh"

module last_note_priority_stack #(
    parameter int CHANNELS = lnps_pkg::CHANNELS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    lnps_item_if.sink      i_item,
    lnps_result_if.source  o_result,
    lnps_cfg_if.sink       i_cfg
);

    lnps_pkg::t_cmd cmd;
    lnps_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    lnps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lnps_dp #(.CHANNELS(CHANNELS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_item.kind),
        .i_chan         (i_item.chan),
        .i_note         (i_item.note),
        .i_velocity     (i_item.velocity),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_top_note     (o_result.top_note),
        .o_top_velocity (o_result.top_velocity),
        .o_any_held     (o_result.any_held)
    );

    `LNPS_ASSERT_NXT(a_one_word, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready)
    `LNPS_ASSERT_IMP(a_push_after_decide, i_clk, i_rst_n, cmd.push, $past(cmd.decide))
    `LNPS_ASSERT_IMP(a_held_flag, i_clk, i_rst_n, o_result.valid, o_result.any_held == (o_result.top_note != lnps_pkg::SENTINEL))
    `LNPS_ASSERT_IMP(a_held_range, i_clk, i_rst_n, o_result.valid && o_result.any_held, !o_result.top_note[7] && !o_result.top_velocity[7])

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for last_note_priority_stack: note events and register writes drive a
// local last-note stack predictor, and result words are checked against it under random idling.
// Depends on lnps_pkg and the channel interfaces in lnps_if.sv.

module testbench;

    localparam int STALL_LIMIT = 3000;
    localparam int NCHAN       = 2;

    typedef struct packed {
        logic [lnps_pkg::KIND_W-1:0] kind;
        logic                        chan;
        logic [lnps_pkg::NOTE_W-1:0] note;
        logic [lnps_pkg::VEL_W-1:0]  velocity;
    } t_midi_event;

    typedef struct packed {
        logic [lnps_pkg::SLOT_W-1:0] top_note;
        logic [lnps_pkg::SLOT_W-1:0] top_velocity;
        logic                        any_held;
    } t_voice_state;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lnps_item_if   event_bus ();
    lnps_result_if voice_bus ();
    lnps_cfg_if    reg_bus ();

    last_note_priority_stack #(.CHANNELS(NCHAN)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (event_bus),
        .o_result (voice_bus),
        .i_cfg    (reg_bus)
    );

    // predictor state: per-channel linked list over 128 notes plus the sentinel
    logic [lnps_pkg::SLOT_W-1:0] link_back [NCHAN][129];
    logic [lnps_pkg::SLOT_W-1:0] link_fwd  [NCHAN][129];
    bit                          note_down [NCHAN][128];
    logic [lnps_pkg::VEL_W-1:0]  note_vel  [NCHAN][128];
    logic [lnps_pkg::SLOT_W-1:0] stack_top [NCHAN];
    int                          range_lo  [NCHAN];
    int                          range_hi  [NCHAN];

    t_midi_event  pending_events [$];
    t_voice_state expected_voices [$];
    t_midi_event  outgoing;
    t_voice_state got_voice, want_voice;

    int pool_lo [NCHAN];
    int pool_hi [NCHAN];
    bit send_calm, recv_calm;
    int send_wait, recv_wait;
    int recv_gap;
    int idle_cycles;
    int mismatches = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 5));
    endfunction

    function automatic void unlink_note(int c, int n);
        int p, q;
        p = int'(link_back[c][n]);
        q = int'(link_fwd[c][n]);
        link_fwd[c][p] = q[lnps_pkg::SLOT_W-1:0];
        link_back[c][q] = p[lnps_pkg::SLOT_W-1:0];
    endfunction

    function automatic t_voice_state play_event(t_midi_event ev);
        t_voice_state vs;
        int c, n, t;
        bit ok;
        c = int'(ev.chan);
        n = int'(ev.note);
        t = int'(stack_top[c]);
        ok = (n >= range_lo[c]) && (n <= range_hi[c]);
        if (ev.kind == lnps_pkg::KIND_NOTE_ON && ok) begin
            if (note_down[c][n] && n != t)
                unlink_note(c, n);
            note_down[c][n] = 1'b1;
            note_vel[c][n] = ev.velocity;
            if (n != t) begin
                link_fwd[c][t] = n[lnps_pkg::SLOT_W-1:0];
                link_back[c][n] = t[lnps_pkg::SLOT_W-1:0];
                stack_top[c] = n[lnps_pkg::SLOT_W-1:0];
            end
        end else if (ev.kind == lnps_pkg::KIND_NOTE_OFF && ok && note_down[c][n]) begin
            note_down[c][n] = 1'b0;
            if (n == t)
                stack_top[c] = link_back[c][n];
            else
                unlink_note(c, n);
        end else if (ev.kind == lnps_pkg::KIND_ALL_OFF) begin
            for (int i = 0; i < 128; i++)
                note_down[c][i] = 1'b0;
            stack_top[c] = lnps_pkg::SENTINEL;
        end
        t = int'(stack_top[c]);
        if (t != int'(lnps_pkg::SENTINEL)) begin
            vs.top_note = t[lnps_pkg::SLOT_W-1:0];
            vs.top_velocity = {1'b0, note_vel[c][t]};
            vs.any_held = 1'b1;
        end else begin
            vs.top_note = lnps_pkg::SENTINEL;
            vs.top_velocity = lnps_pkg::SENTINEL;
            vs.any_held = 1'b0;
        end
        return vs;
    endfunction

    function automatic t_midi_event random_event();
        t_midi_event ev;
        int pick;
        int c;
        int val;
        c = int'($urandom_range(0, 1));
        ev.chan = c[0];
        pick = int'($urandom_range(0, 99));
        if (pick < 50)
            ev.kind = lnps_pkg::KIND_NOTE_ON;
        else if (pick < 88)
            ev.kind = lnps_pkg::KIND_NOTE_OFF;
        else if (pick < 91)
            ev.kind = lnps_pkg::KIND_ALL_OFF;
        else
            ev.kind = lnps_pkg::KIND_QUERY;
        if ($urandom_range(0, 4) == 0)
            val = int'($urandom_range(0, 127));
        else
            val = int'($urandom_range(pool_lo[c], pool_hi[c]));
        ev.note = val[lnps_pkg::NOTE_W-1:0];
        val = int'($urandom_range(0, 127));
        ev.velocity = val[lnps_pkg::VEL_W-1:0];
        return ev;
    endfunction

    task automatic add_event(logic [lnps_pkg::KIND_W-1:0] kind, logic chan, int note,
                             int velocity);
        t_midi_event ev;
        ev.kind = kind;
        ev.chan = chan;
        ev.note = note[lnps_pkg::NOTE_W-1:0];
        ev.velocity = velocity[lnps_pkg::VEL_W-1:0];
        pending_events.push_back(ev);
    endtask

    task automatic settle();
        while (pending_events.size() != 0 || event_bus.valid || expected_voices.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lnps_pkg::CFG_IDX_W-1:0] index, int value);
        @(posedge i_clk);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= index;
        reg_bus.data <= value[lnps_pkg::NOTE_W-1:0];
        do @(posedge i_clk); while (!(reg_bus.valid && reg_bus.ready));
        case (index)
            lnps_pkg::REG_CH0_LOWEST:  range_lo[0] = value;
            lnps_pkg::REG_CH0_HIGHEST: range_hi[0] = value;
            lnps_pkg::REG_CH1_LOWEST:  range_lo[1] = value;
            lnps_pkg::REG_CH1_HIGHEST: range_hi[1] = value;
            default: begin
            end
        endcase
        reg_bus.valid <= 1'b0;
    endtask

    task automatic set_ranges(int lo0, int hi0, int lo1, int hi1);
        int span, base;
        write_reg(lnps_pkg::REG_CH0_LOWEST, lo0);
        write_reg(lnps_pkg::REG_CH0_HIGHEST, hi0);
        write_reg(lnps_pkg::REG_CH1_LOWEST, lo1);
        write_reg(lnps_pkg::REG_CH1_HIGHEST, hi1);
        // aim most random notes at a narrow window inside the range so stacks grow
        for (int c = 0; c < NCHAN; c++) begin
            if (range_lo[c] <= range_hi[c]) begin
                span = range_hi[c] - range_lo[c];
                base = range_lo[c] + int'($urandom_range(0, span > 11 ? span - 11 : 0));
            end else begin
                base = int'($urandom_range(0, 116));
            end
            pool_lo[c] = base;
            pool_hi[c] = (base + 11 > 127) ? 127 : base + 11;
            if (range_lo[c] <= range_hi[c] && pool_hi[c] > range_hi[c])
                pool_hi[c] = range_hi[c];
        end
    endtask

    task automatic play_random(int count);
        t_midi_event ev;
        int taken;
        taken = 0;
        while (taken < count) begin
            if (taken % 50 == 0) begin
                while (pending_events.size() != 0)
                    @(posedge i_clk);
                send_calm = ($urandom_range(0, 3) == 0);
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            ev = random_event();
            pending_events.push_back(ev);
            if (ev.kind == lnps_pkg::KIND_ALL_OFF || ev.kind == lnps_pkg::KIND_QUERY ||
                (int'(ev.note) >= range_lo[ev.chan] && int'(ev.note) <= range_hi[ev.chan]))
                taken++;
        end
    endtask

    // driver: hold each word until taken, then idle for the drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            event_bus.valid <= 1'b0;
            send_wait <= 0;
        end else begin
            if (event_bus.valid && event_bus.ready)
                expected_voices.push_back(play_event({event_bus.kind, event_bus.chan,
                                                      event_bus.note, event_bus.velocity}));
            if (!event_bus.valid || event_bus.ready) begin
                if (send_wait != 0) begin
                    event_bus.valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (pending_events.size() != 0) begin
                    outgoing = pending_events.pop_front();
                    event_bus.valid <= 1'b1;
                    event_bus.kind <= outgoing.kind;
                    event_bus.chan <= outgoing.chan;
                    event_bus.note <= outgoing.note;
                    event_bus.velocity <= outgoing.velocity;
                    send_wait <= draw_wait(send_calm);
                end else begin
                    event_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest prediction, then stall for the drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            voice_bus.ready <= 1'b0;
            recv_wait <= 0;
        end else if (voice_bus.valid && voice_bus.ready) begin
            got_voice = {voice_bus.top_note, voice_bus.top_velocity, voice_bus.any_held};
            if (expected_voices.size() == 0) begin
                $display("%0t: expected no word, got note %0d velocity %0d held %0b",
                         $time, got_voice.top_note, got_voice.top_velocity, got_voice.any_held);
                mismatches++;
            end else begin
                want_voice = expected_voices.pop_front();
                if (got_voice !== want_voice) begin
                    $display("%0t: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                             $time, want_voice.top_note, want_voice.top_velocity,
                             want_voice.any_held, got_voice.top_note,
                             got_voice.top_velocity, got_voice.any_held);
                    mismatches++;
                end
            end
            recv_gap = draw_wait(recv_calm);
            recv_wait <= recv_gap;
            voice_bus.ready <= (recv_gap == 0);
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            voice_bus.ready <= (recv_wait == 1);
        end else begin
            voice_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((event_bus.valid && event_bus.ready) || (voice_bus.valid && voice_bus.ready)
                     || (reg_bus.valid && reg_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int c = 0; c < NCHAN; c++) begin
            for (int i = 0; i < 129; i++) begin
                link_back[c][i] = lnps_pkg::SENTINEL;
                link_fwd[c][i] = lnps_pkg::SENTINEL;
            end
            for (int i = 0; i < 128; i++) begin
                note_down[c][i] = 1'b0;
                note_vel[c][i] = '0;
            end
            stack_top[c] = lnps_pkg::SENTINEL;
            range_lo[c] = int'(lnps_pkg::RST_LOWEST);
            range_hi[c] = int'(lnps_pkg::RST_HIGHEST);
        end
        send_calm = 1'b0;
        recv_calm = 1'b0;
        i_rst_n = 1'b0;
        event_bus.valid = 1'b0;
        event_bus.kind = lnps_pkg::KIND_QUERY;
        event_bus.chan = 1'b0;
        event_bus.note = '0;
        event_bus.velocity = '0;
        voice_bus.ready = 1'b0;
        reg_bus.valid = 1'b0;
        reg_bus.index = lnps_pkg::REG_CH0_LOWEST;
        reg_bus.data = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_ranges(0, 127, 0, 127);
        add_event(lnps_pkg::KIND_NOTE_ON, 0, 0, 0);
        add_event(lnps_pkg::KIND_NOTE_ON, 0, 127, 127);
        add_event(lnps_pkg::KIND_NOTE_ON, 0, 64, 85);
        add_event(lnps_pkg::KIND_NOTE_ON, 0, 0, 42);
        add_event(lnps_pkg::KIND_NOTE_ON, 0, 0, 43);
        add_event(lnps_pkg::KIND_NOTE_OFF, 0, 100, 5);
        add_event(lnps_pkg::KIND_NOTE_OFF, 0, 0, 0);
        add_event(lnps_pkg::KIND_NOTE_OFF, 0, 127, 0);
        add_event(lnps_pkg::KIND_QUERY, 0, 127, 127);
        add_event(lnps_pkg::KIND_NOTE_OFF, 0, 64, 0);
        add_event(lnps_pkg::KIND_NOTE_OFF, 0, 64, 0);
        add_event(lnps_pkg::KIND_NOTE_ON, 1, 85, 1);
        add_event(lnps_pkg::KIND_NOTE_ON, 1, 42, 126);
        add_event(lnps_pkg::KIND_NOTE_ON, 1, 85, 2);
        add_event(lnps_pkg::KIND_ALL_OFF, 1, 127, 127);
        add_event(lnps_pkg::KIND_QUERY, 1, 0, 0);
        add_event(lnps_pkg::KIND_NOTE_ON, 1, 42, 0);
        add_event(lnps_pkg::KIND_NOTE_ON, 0, 21, 106);
        add_event(lnps_pkg::KIND_NOTE_ON, 0, 106, 21);
        add_event(lnps_pkg::KIND_ALL_OFF, 0, 0, 0);
        add_event(lnps_pkg::KIND_NOTE_OFF, 0, 21, 0);
        add_event(lnps_pkg::KIND_QUERY, 0, 0, 0);
        add_event(lnps_pkg::KIND_NOTE_ON, 0, 21, 127);
        play_random(120);

        // leave notes held, then narrow the ranges so some fall outside
        add_event(lnps_pkg::KIND_ALL_OFF, 0, 0, 0);
        add_event(lnps_pkg::KIND_ALL_OFF, 1, 0, 0);
        add_event(lnps_pkg::KIND_NOTE_ON, 0, 10, 9);
        add_event(lnps_pkg::KIND_NOTE_ON, 0, 60, 33);
        add_event(lnps_pkg::KIND_NOTE_ON, 1, 5, 77);
        settle();
        set_ranges(40, 80, 100, 127);
        add_event(lnps_pkg::KIND_NOTE_OFF, 0, 10, 0);
        add_event(lnps_pkg::KIND_QUERY, 0, 0, 0);
        add_event(lnps_pkg::KIND_NOTE_OFF, 0, 60, 0);
        add_event(lnps_pkg::KIND_QUERY, 0, 0, 0);
        add_event(lnps_pkg::KIND_NOTE_OFF, 1, 5, 0);
        add_event(lnps_pkg::KIND_ALL_OFF, 1, 0, 0);
        add_event(lnps_pkg::KIND_NOTE_ON, 1, 100, 1);
        add_event(lnps_pkg::KIND_NOTE_ON, 1, 127, 126);
        play_random(120);

        settle();
        set_ranges(127, 127, 0, 0);
        play_random(60);

        settle();
        set_ranges(127, 0, 0, 127);
        play_random(80);

        settle();
        set_ranges(0, 127, 20, 90);
        play_random(90);
        settle();
        play_random(90);

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_voices.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
